/* design/ccbs_pkg.sv */
// Calendar clock package: field widths, codes, reset values and payload structs.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package ccbs_pkg;

	// input mode codes
	localparam logic [1:0] MODE_MS_TICK  = 2'd0;
	localparam logic [1:0] MODE_SEC_TICK = 2'd1;
	localparam logic [1:0] MODE_SW_SET   = 2'd2;
	localparam logic [1:0] MODE_BKP_LOAD = 2'd3;

	// configuration register indexes
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_RESYNC_PERIOD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FLASH_MS      = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_YEAR      = 2'd2;

	// field limits
	localparam logic [9:0] MS_MAX    = 10'd999;
	localparam logic [5:0] SEC_MAX   = 6'd59;
	localparam logic [5:0] MIN_MAX   = 6'd59;
	localparam logic [4:0] HOUR_MAX  = 5'd23;
	localparam logic [3:0] MONTH_MAX = 4'd12;

	// sync counter value that marks a pending backup write
	localparam logic [15:0] SAVE_PENDING = 16'hffff;

	// register reset values
	localparam logic [15:0] RESYNC_PERIOD_RST = 16'd1800;
	localparam logic [9:0]  FLASH_MS_RST      = 10'd450;
	localparam logic [6:0]  MAX_YEAR_RST      = 7'd50;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
	} ccbs_time_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] in_year;
		logic [3:0] in_month;
		logic [4:0] in_day;
		logic [4:0] in_hour;
		logic [5:0] in_minute;
		logic [5:0] in_second;
		logic [9:0] in_millisecond;
	} ccbs_in_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
		logic       time_valid;
		logic       flash;
		logic       save_request;
		logic       resync_request;
	} ccbs_out_t;

	// month length, leap year every fourth year, unknown months count 31
	function automatic logic [4:0] days_in_month(logic [6:0] yr, logic [3:0] mo);
		logic [4:0] d;
		unique case (mo) inside
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2:                    d = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* design/ccbs_if.sv */
// Handshake channels of the calendar clock: item input, result output, config write.
// Depends on ccbs_pkg for the payload types.
`default_nettype none

interface ccbs_in_if import ccbs_pkg::*; ();
	logic     valid;
	logic     ready;
	ccbs_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ccbs_out_if import ccbs_pkg::*; ();
	logic      valid;
	logic      ready;
	ccbs_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ccbs_cfg_if import ccbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* design/calendar_clock_with_backup_sync_unit.sv */
// Calendar clock top level: time registers, tick cascade, backup sync control.
// Depends on ccbs_pkg and the channel interfaces in ccbs_if.sv.
//
// Usage:
//   req  - one item per transfer: a millisecond tick, a one-second housekeeping
//          tick, a software set or a load from the backup clock.
//   rsp  - exactly one result per item: the time after the item, time_valid,
//          flash phase and the save/resync requests to the backup clock.
//   cfg  - register writes (resync_period, flash_ms, max_year); always ready.
//          Write only while no result is outstanding.
// Each result is registered: in the output register, or in the skid register.
// Throughput: one item per cycle while req.ready is high, set by the single
//   registered pass through the carry cascade and validity check.
// A two-entry output buffer (result register plus skid register) lets req
//   keep transferring while one result waits on a stalled receiver; req.ready
//   drops only when both entries are full.
// Reset (arst_n low, asynchronous): time goes to 00-01-01 00:00:00.000,
//   sync counter to 0, registers to their defaults, output buffer empties.
`default_nettype none

module calendar_clock_with_backup_sync_unit
	import ccbs_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	ccbs_in_if.sink      req,
	ccbs_out_if.source   rsp,
	ccbs_cfg_if.sink     cfg
);

	// every field within its legal range
	function automatic logic time_ok(ccbs_time_t t, logic [6:0] max_yr);
		return (t.year <= max_yr)
			&& (t.month >= 4'd1) && (t.month <= MONTH_MAX)
			&& (t.day >= 5'd1) && (t.day <= days_in_month(t.year, t.month))
			&& (t.hour <= HOUR_MAX) && (t.minute <= MIN_MAX)
			&& (t.second <= SEC_MAX) && (t.millisecond <= MS_MAX);
	endfunction

	// configuration registers
	logic [15:0] resync_period_q;
	logic [9:0]  flash_ms_q;
	logic [6:0]  max_year_q;

	// clock state
	ccbs_time_t  time_q;
	logic [15:0] sync_q;

	// output buffer
	ccbs_out_t   out_q;
	logic        out_vld_q;
	ccbs_out_t   skid_q;
	logic        skid_vld_q;

	logic        in_xfer;
	logic        out_xfer;

	ccbs_time_t  time_nxt;
	logic [15:0] sync_nxt;
	logic [15:0] sync_inc;
	logic        save;
	logic        resync;
	ccbs_out_t   res;

	// carry flags: field would pass its limit on increment
	logic        ms_ovf, sec_ovf, min_ovf, hour_ovf, day_ovf, mon_ovf;

	assign cfg.ready = 1'b1;
	assign req.ready = !skid_vld_q;
	assign in_xfer   = req.valid && req.ready;
	assign out_xfer  = out_vld_q && rsp.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_period_q <= RESYNC_PERIOD_RST;
			flash_ms_q      <= FLASH_MS_RST;
			max_year_q      <= MAX_YEAR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_RESYNC_PERIOD: resync_period_q <= cfg.data;
				REG_FLASH_MS:      flash_ms_q      <= cfg.data[9:0];
				REG_MAX_YEAR:      max_year_q      <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// a limit compare on the current value is the same as incremented > limit
	assign ms_ovf   = time_q.millisecond >= MS_MAX;
	assign sec_ovf  = time_q.second >= SEC_MAX;
	assign min_ovf  = time_q.minute >= MIN_MAX;
	assign hour_ovf = time_q.hour >= HOUR_MAX;
	assign day_ovf  = time_q.day >= days_in_month(time_q.year, time_q.month);
	assign mon_ovf  = time_q.month >= MONTH_MAX;
	assign sync_inc = sync_q + 16'd1;

	always_comb begin
		time_nxt = time_q;
		sync_nxt = sync_q;
		save     = 1'b0;
		resync   = 1'b0;
		unique case (req.data.mode)
			MODE_MS_TICK: begin
				time_nxt.millisecond = ms_ovf ? 10'd0 : time_q.millisecond + 10'd1;
				if (ms_ovf)
					time_nxt.second = sec_ovf ? 6'd0 : time_q.second + 6'd1;
				if (ms_ovf && sec_ovf)
					time_nxt.minute = min_ovf ? 6'd0 : time_q.minute + 6'd1;
				if (ms_ovf && sec_ovf && min_ovf)
					time_nxt.hour = hour_ovf ? 5'd0 : time_q.hour + 5'd1;
				if (ms_ovf && sec_ovf && min_ovf && hour_ovf)
					time_nxt.day = day_ovf ? 5'd1 : time_q.day + 5'd1;
				if (ms_ovf && sec_ovf && min_ovf && hour_ovf && day_ovf)
					time_nxt.month = mon_ovf ? 4'd1 : time_q.month + 4'd1;
				if (ms_ovf && sec_ovf && min_ovf && hour_ovf && day_ovf && mon_ovf)
					time_nxt.year = time_q.year + 7'd1;   // wraps at 127
			end
			MODE_SEC_TICK: begin
				save = (sync_q == SAVE_PENDING) && time_ok(time_q, max_year_q);
				if (sync_inc >= resync_period_q) begin
					sync_nxt = '0;
					resync   = 1'b1;
				end else begin
					sync_nxt = sync_inc;
				end
			end
			MODE_SW_SET, MODE_BKP_LOAD: begin
				time_nxt.year        = req.data.in_year;
				time_nxt.month       = req.data.in_month;
				time_nxt.day         = req.data.in_day;
				time_nxt.hour        = req.data.in_hour;
				time_nxt.minute      = req.data.in_minute;
				time_nxt.second      = req.data.in_second;
				time_nxt.millisecond = req.data.in_millisecond;
				// only a software set arms the backup write
				if (req.data.mode == MODE_SW_SET)
					sync_nxt = SAVE_PENDING;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.year           = time_nxt.year;
		res.month          = time_nxt.month;
		res.day            = time_nxt.day;
		res.hour           = time_nxt.hour;
		res.minute         = time_nxt.minute;
		res.second         = time_nxt.second;
		res.millisecond    = time_nxt.millisecond;
		res.time_valid     = time_ok(time_nxt, max_year_q);
		res.flash          = time_nxt.millisecond < flash_ms_q;
		res.save_request   = save;
		res.resync_request = resync;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, second: 6'd0, millisecond: 10'd0};
			sync_q <= '0;
		end else if (in_xfer) begin
			time_q <= time_nxt;
			sync_q <= sync_nxt;
		end
	end

	// output register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_xfer) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_xfer;
			end
		end else if (in_xfer) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= res;
			end
		end else if (in_xfer) begin
			if (out_vld_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

endmodule

`default_nettype wire

/* design/ccbs_checker.sv */
// Port-level checks for the calendar clock top level, attached by bind.
// Depends on ccbs_pkg for the result struct and field limits.
`default_nettype none

module ccbs_checker
	import ccbs_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       rsp_valid,
	input wire       rsp_ready,
	input ccbs_out_t rsp_data
);

	// after every item transfer a result is valid in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after item transfer");

	// a backup write is only requested for a valid time
	a_save_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.save_request |-> rsp_data.time_valid)
		else $error("save request on invalid time");

	// a valid time has ms, second, minute, hour and month in range and a nonzero day
	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.time_valid |->
			rsp_data.millisecond <= MS_MAX && rsp_data.second <= SEC_MAX
			&& rsp_data.minute <= MIN_MAX && rsp_data.hour <= HOUR_MAX
			&& rsp_data.day != 5'd0 && rsp_data.month != 4'd0
			&& rsp_data.month <= MONTH_MAX)
		else $error("time_valid with field out of range");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

endmodule

bind calendar_clock_with_backup_sync_unit ccbs_checker u_ccbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

/* bench/ccbs_clock_checker.sv */
// Scoreboard for the calendar clock: watches the item, result and register-write
// channels, keeps its own copy of the clock and compares every result in order.
// Depends on ccbs_pkg for payload types, mode codes, register indexes and limits.

module ccbs_clock_checker
	import ccbs_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	input  wire                  req_ready,
	input  ccbs_in_t             req_data,
	input  wire                  rsp_valid,
	input  wire                  rsp_ready,
	input  ccbs_out_t            rsp_data,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire [CFG_ADDR_W-1:0] cfg_addr,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   saves_seen,
	output int                   resyncs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	ccbs_out_t pending_results[$];

	// predicted clock state
	logic [9:0]  ms_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hr_q;
	logic [4:0]  day_q;
	logic [3:0]  mon_q;
	logic [6:0]  yr_q;
	logic [15:0] sync_q;

	// register copies
	logic [15:0] period_q;
	logic [9:0]  flash_q;
	logic [6:0]  maxyr_q;

	function automatic int month_days(input logic [6:0] yr, input logic [3:0] mo);
		case (mo)
			4'd4, 4'd6, 4'd9, 4'd11: return 30;
			4'd2: return (yr[1:0] == 2'b00) ? 29 : 28;
			default: return 31;
		endcase
	endfunction

	function automatic bit clock_legal();
		return (yr_q <= maxyr_q) && (mon_q >= 4'd1) && (mon_q <= MONTH_MAX) &&
			(day_q >= 5'd1) && (int'(day_q) <= month_days(yr_q, mon_q)) &&
			(hr_q <= HOUR_MAX) && (min_q <= MIN_MAX) && (sec_q <= SEC_MAX) &&
			(ms_q <= MS_MAX);
	endfunction

	// carry cascade; wide sums so out-of-range fields roll over instead of wrapping
	task automatic tick_millisecond();
		int v;
		v = int'(ms_q) + 1;
		if (v <= int'(MS_MAX)) begin
			ms_q = v[9:0];
			return;
		end
		ms_q = '0;
		v = int'(sec_q) + 1;
		if (v <= int'(SEC_MAX)) begin
			sec_q = v[5:0];
			return;
		end
		sec_q = '0;
		v = int'(min_q) + 1;
		if (v <= int'(MIN_MAX)) begin
			min_q = v[5:0];
			return;
		end
		min_q = '0;
		v = int'(hr_q) + 1;
		if (v <= int'(HOUR_MAX)) begin
			hr_q = v[4:0];
			return;
		end
		hr_q = '0;
		v = int'(day_q) + 1;
		if (v <= month_days(yr_q, mon_q)) begin
			day_q = v[4:0];
			return;
		end
		day_q = 5'd1;
		v = int'(mon_q) + 1;
		if (v <= int'(MONTH_MAX)) begin
			mon_q = v[3:0];
			return;
		end
		mon_q = 4'd1;
		yr_q = yr_q + 7'd1;
	endtask

	task automatic load_fields(input ccbs_in_t it);
		yr_q  = it.in_year;
		mon_q = it.in_month;
		day_q = it.in_day;
		hr_q  = it.in_hour;
		min_q = it.in_minute;
		sec_q = it.in_second;
		ms_q  = it.in_millisecond;
	endtask

	task automatic step_clock(input ccbs_in_t it, output ccbs_out_t r);
		r = '0;
		case (it.mode)
			MODE_MS_TICK: tick_millisecond();
			MODE_SEC_TICK: begin
				r.save_request = (sync_q == SAVE_PENDING) && clock_legal();
				sync_q = sync_q + 16'd1;
				if (sync_q >= period_q) begin
					sync_q = '0;
					r.resync_request = 1'b1;
				end
			end
			MODE_SW_SET: begin
				load_fields(it);
				sync_q = SAVE_PENDING;
			end
			default: load_fields(it);
		endcase
		r.year        = yr_q;
		r.month       = mon_q;
		r.day         = day_q;
		r.hour        = hr_q;
		r.minute      = min_q;
		r.second      = sec_q;
		r.millisecond = ms_q;
		r.time_valid  = clock_legal();
		r.flash       = (ms_q < flash_q);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_result(input ccbs_out_t want, input ccbs_out_t got);
		check_field("year", 16'(want.year), 16'(got.year));
		check_field("month", 16'(want.month), 16'(got.month));
		check_field("day", 16'(want.day), 16'(got.day));
		check_field("hour", 16'(want.hour), 16'(got.hour));
		check_field("minute", 16'(want.minute), 16'(got.minute));
		check_field("second", 16'(want.second), 16'(got.second));
		check_field("millisecond", 16'(want.millisecond), 16'(got.millisecond));
		check_field("time_valid", 16'(want.time_valid), 16'(got.time_valid));
		check_field("flash", 16'(want.flash), 16'(got.flash));
		check_field("save_request", 16'(want.save_request), 16'(got.save_request));
		check_field("resync_request", 16'(want.resync_request),
			16'(got.resync_request));
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		ccbs_out_t want;
		if (!arst_n) begin
			pending_results.delete();
			ms_q = '0;
			sec_q = '0;
			min_q = '0;
			hr_q = '0;
			day_q = 5'd1;
			mon_q = 4'd1;
			yr_q = '0;
			sync_q = '0;
			period_q = RESYNC_PERIOD_RST;
			flash_q = FLASH_MS_RST;
			maxyr_q = MAX_YEAR_RST;
			mismatches = 0;
			outstanding = 0;
			saves_seen = 0;
			resyncs_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					REG_RESYNC_PERIOD: period_q = cfg_data;
					REG_FLASH_MS:      flash_q = cfg_data[9:0];
					REG_MAX_YEAR:      maxyr_q = cfg_data[6:0];
					default: ;
				endcase
			end
			// results always come after their item transfers, so retire before predicting
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no item pending: %0d-%0d-%0d %0d:%0d:%0d.%0d",
						rsp_data.year, rsp_data.month, rsp_data.day, rsp_data.hour,
						rsp_data.minute, rsp_data.second, rsp_data.millisecond);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compare_result(want, rsp_data);
				end
			end
			if (req_valid && req_ready) begin
				step_clock(req_data, want);
				if (want.save_request)
					saves_seen++;
				if (want.resync_request)
					resyncs_seen++;
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* bench/tb_calendar_clock_with_backup_sync_unit.sv */
// Top of the calendar clock bench: clock, reset, item and register-write stimulus,
// receiver stalls, watchdog and verdict. Depends on ccbs_pkg, the channel
// interfaces and ccbs_clock_checker, which does all prediction and comparison.

module tb_calendar_clock_with_backup_sync_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ccbs_pkg::*;

	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 316;
	// ~1900 items; worst case is a heavy receiver stall window plus sender gaps,
	// and this limit still leaves a wide margin
	localparam int CYCLE_LIMIT     = 400000;

	logic clk = 1'b0;
	logic arst_n;

	ccbs_in_if  req_ch ();
	ccbs_out_if rsp_ch ();
	ccbs_cfg_if cfg_ch ();

	int mismatches;
	int outstanding;
	int saves_seen;
	int resyncs_seen;

	int cycle_count = 0;
	int burst_left = 0;
	int mode_count[4] = '{default: 0};
	logic [10:0] stall_cnt = '0;

	calendar_clock_with_backup_sync_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	ccbs_clock_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.req_data     (req_ch.data),
		.rsp_valid    (rsp_ch.valid),
		.rsp_ready    (rsp_ch.ready),
		.rsp_data     (rsp_ch.data),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_addr     (cfg_ch.addr),
		.cfg_data     (cfg_ch.data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.saves_seen   (saves_seen),
		.resyncs_seen (resyncs_seen)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver stall pattern, rotating through four windows set by stall_cnt[10:9]:
	// always ready, light random stalls, a fixed stall whenever stall_cnt[3:1] is zero, and
	// heavy random stalls that fill the output skid buffer and push back on req.
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 11'd1;
		case (stall_cnt[10:9])
			2'd0: rsp_ch.ready <= 1'b1;
			2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			2'd2: rsp_ch.ready <= (stall_cnt[3:1] != 3'd0);
			default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	function automatic ccbs_in_t make_item(input logic [1:0] md, input int yr, input int mo,
			input int dy, input int hr, input int mi, input int se, input int msec);
		ccbs_in_t it;
		it.mode           = md;
		it.in_year        = yr[6:0];
		it.in_month       = mo[3:0];
		it.in_day         = dy[4:0];
		it.in_hour        = hr[4:0];
		it.in_minute      = mi[5:0];
		it.in_second      = se[5:0];
		it.in_millisecond = msec[9:0];
		return it;
	endfunction

	// Mostly millisecond ticks so loaded times actually roll over; loads are
	// usually constrained times close to a boundary, otherwise raw random bits.
	function automatic ccbs_in_t random_item();
		ccbs_in_t it;
		int pick;
		it.in_year        = 7'($urandom);
		it.in_month       = 4'($urandom);
		it.in_day         = 5'($urandom);
		it.in_hour        = 5'($urandom);
		it.in_minute      = 6'($urandom);
		it.in_second      = 6'($urandom);
		it.in_millisecond = 10'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.mode = MODE_MS_TICK;
		else if (pick < 78)
			it.mode = MODE_SEC_TICK;
		else if (pick < 89)
			it.mode = MODE_SW_SET;
		else
			it.mode = MODE_BKP_LOAD;
		if ((it.mode == MODE_SW_SET || it.mode == MODE_BKP_LOAD) && $urandom_range(0, 9) < 7) begin
			it.in_year   = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom_range(0, 60));
			it.in_month  = 4'($urandom_range(1, 12));
			it.in_day    = 5'($urandom_range(0, 1) ? $urandom_range(28, 31)
				: $urandom_range(1, 28));
			it.in_hour   = 5'($urandom_range(0, 1) ? 23 : $urandom_range(0, 23));
			it.in_minute = 6'($urandom_range(0, 1) ? 59 : $urandom_range(0, 59));
			it.in_second = 6'($urandom_range(0, 1) ? 59 : $urandom_range(0, 59));
			it.in_millisecond = 10'($urandom_range(0, 1) ? $urandom_range(980, 999)
				: $urandom_range(0, 999));
		end
		return it;
	endfunction

	// One item transfer. Bursts of random length; between bursts valid drops for a
	// random gap. A zero gap keeps valid high so back-to-back bursts merge.
	task automatic send_item(input ccbs_in_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		mode_count[it.mode]++;
	endtask

	// Stop sending and wait until every result is back; sampled on the falling
	// edge so the checker's count for this cycle is settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	// Writes all three registers back to back, valid held across the three
	// transfers and dropped once after the last.
	task automatic write_regs(input logic [15:0] period, input logic [9:0] flash_lim,
			input logic [6:0] year_lim);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= REG_RESYNC_PERIOD;
		cfg_ch.data  <= period;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.addr <= REG_FLASH_MS;
		cfg_ch.data <= CFG_DATA_W'(flash_lim);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.addr <= REG_MAX_YEAR;
		cfg_ch.data <= CFG_DATA_W'(year_lim);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0] period;
		logic [9:0]  flash_lim;
		logic [6:0]  year_lim;

		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr  <= REG_RESYNC_PERIOD;
		cfg_ch.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, register defaults (max year 50, flash below 450).
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_SEC_TICK, 0, 0, 0, 0, 0, 0, 0));
		// largest legal time in year 127: invalid (above max year), so no save
		send_item(make_item(MODE_SW_SET, 127, 12, 31, 23, 59, 59, 999));
		send_item(make_item(MODE_SEC_TICK, 0, 0, 0, 0, 0, 0, 0));
		// full cascade, year wraps to 0; the last second tick took the sync counter off the pending mark, so no save
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_SEC_TICK, 0, 0, 0, 0, 0, 0, 0));
		// every field at its all-ones value rolls over on the next tick
		send_item(make_item(MODE_SW_SET, 127, 15, 31, 31, 63, 63, 1023));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// unknown month counts 31 days
		send_item(make_item(MODE_BKP_LOAD, 5, 0, 31, 23, 59, 59, 999));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// leap February 28 -> 29 -> March 1
		send_item(make_item(MODE_BKP_LOAD, 4, 2, 28, 23, 59, 59, 999));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_BKP_LOAD, 4, 2, 29, 23, 59, 59, 999));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// common-year February ends on the 28th
		send_item(make_item(MODE_BKP_LOAD, 5, 2, 28, 23, 59, 59, 999));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// 30-day month
		send_item(make_item(MODE_BKP_LOAD, 10, 4, 30, 23, 59, 59, 999));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// day zero is invalid
		send_item(make_item(MODE_BKP_LOAD, 10, 6, 0, 12, 30, 30, 500));
		send_item(make_item(MODE_SEC_TICK, 0, 0, 0, 0, 0, 0, 0));
		// Feb 29 in a common year at the max year, flash edge 449 -> 450
		send_item(make_item(MODE_SW_SET, 50, 2, 29, 0, 0, 0, 449));
		send_item(make_item(MODE_MS_TICK, 0, 0, 0, 0, 0, 0, 0));
		// one year past the limit, then everything zero
		send_item(make_item(MODE_SW_SET, 51, 1, 1, 0, 0, 0, 0));
		send_item(make_item(MODE_SW_SET, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_SEC_TICK, 0, 0, 0, 0, 0, 0, 0));

		// Random phases, each under its own register setting; extremes first.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					period = 16'd1;
					flash_lim = 10'd0;
					year_lim = 7'd0;
				end
				1: begin
					period = 16'd65534;
					flash_lim = 10'd1000;
					year_lim = 7'd127;
				end
				2: begin
					period = 16'd5;
					flash_lim = 10'd500;
					year_lim = 7'd50;
				end
				3: begin
					period = 16'd2;
					flash_lim = 10'd999;
					year_lim = 7'd127;
				end
				default: begin
					period = 16'($urandom_range(1, 40));
					flash_lim = 10'($urandom_range(0, 1000));
					year_lim = 7'($urandom_range(0, 127));
				end
			endcase
			drain();
			write_regs(period, flash_lim, year_lim);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_item());
		end

		drain();
		repeat (4) @(posedge clk);

		$display("Ran %0d ms ticks, %0d second ticks, %0d software sets, %0d backup loads",
			mode_count[MODE_MS_TICK], mode_count[MODE_SEC_TICK],
			mode_count[MODE_SW_SET], mode_count[MODE_BKP_LOAD]);
		$display("over %0d register settings; %0d backup writes, %0d rereads, %0d mismatches",
			NUM_PHASES + 1, saves_seen, resyncs_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
